// ----- src/q9sf_pkg.sv -----
// Shared types, constants and node tables for the nine-node quad shape function evaluator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package q9sf_pkg;

    localparam int NODE_W  = 4;
    localparam int KIND_W  = 2;
    localparam int COORD_W = 18;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int FACT_W  = 37;
    localparam int OUT_W   = 25;

    localparam logic [NODE_W-1:0] NODE_COUNT = 4'd9;

    localparam logic [KIND_W-1:0] KIND_VALUE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DR    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DS    = 2'd2;

    localparam logic signed [FACT_W-1:0] FACT_TWO31 = 37'sd2147483648;
    localparam logic signed [FACT_W-1:0] FACT_TWO30 = 37'sd1073741824;

    typedef enum logic [1:0] {
        SEL_MINUS,
        SEL_CENTER,
        SEL_PLUS
    } sel_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [SQ_W-1:0]    square_t;
    typedef logic signed [FACT_W-1:0]  factor_t;

    function automatic sel_t r_sel_of(input logic [NODE_W-1:0] node);
        sel_t sel;
        unique case (node)
            4'd0, 4'd3, 4'd7: sel = SEL_MINUS;
            4'd1, 4'd2, 4'd5: sel = SEL_PLUS;
            default:          sel = SEL_CENTER;
        endcase
        return sel;
    endfunction

    function automatic sel_t s_sel_of(input logic [NODE_W-1:0] node);
        sel_t sel;
        unique case (node)
            4'd0, 4'd1, 4'd4: sel = SEL_MINUS;
            4'd2, 4'd3, 4'd6: sel = SEL_PLUS;
            default:          sel = SEL_CENTER;
        endcase
        return sel;
    endfunction

endpackage

`default_nettype wire

// ----- src/quad9_shape_function_eval.sv -----
// Nine-node biquadratic quad shape function evaluator, top level.
// Depends on q9sf_pkg and q9sf_factor.
// Throughput: one request per cycle while the output is not stalled (m_ready high).
// Six register stages, the last is the output register.
// Stages: square, factor select, four partial products, two partial sums, round and clamp.
// A stall holds only the stages behind a full stage; bubbles close up.
// Reset (aresetn low, synchronous) clears all stage valid bits; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module quad9_shape_function_eval (
    input  var logic        aclk,
    input  var logic        aresetn,
    input  var logic        s_valid,
    output var logic        s_ready,
    input  var logic [3:0]  s_node_index,
    input  var logic [1:0]  s_kind,
    input  var logic signed [17:0] s_coord_r,
    input  var logic signed [17:0] s_coord_s,
    output var logic        m_valid,
    input  var logic        m_ready,
    output var logic signed [24:0] m_shape_value
);

    localparam int STAGES = 6;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] rdy;

    // stage 1
    q9sf_pkg::coord_t  r1_reg, s1_reg;
    q9sf_pkg::square_t sqr1_reg, sqs1_reg;
    q9sf_pkg::sel_t    rsel1_reg, ssel1_reg;
    logic              dr1_reg, ds1_reg, en1_reg;
    // stage 2
    q9sf_pkg::factor_t fa2_reg, fb2_reg;
    // stage 3
    logic        [37:0] ll3_reg;
    logic signed [37:0] lh3_reg, hl3_reg;
    logic signed [35:0] hh3_reg;
    // stage 4
    logic signed [38:0] mid4_reg;
    logic signed [35:0] hh4_reg;
    logic        [46:0] low4_reg;
    // stage 5
    logic signed [56:0] acc5_reg;
    logic        [46:0] low5_reg;
    // stage 6
    logic signed [24:0] out_reg;

    q9sf_pkg::factor_t  fr_next, fs_next;
    logic        [18:0] al, bl;
    logic signed [17:0] ah, bh;
    logic signed [76:0] tot_next;
    logic signed [29:0] q_next;
    logic signed [24:0] out_next;
    logic               sat_hi, sat_lo;

    always_comb begin
        rdy[STAGES-1] = !valid_reg[STAGES-1] || m_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    assign s_ready       = rdy[0];
    assign m_valid       = valid_reg[STAGES-1];
    assign m_shape_value = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (rdy[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (rdy[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // stage 1: squares and table lookup
    always_ff @(posedge aclk) begin
        if (rdy[0] && s_valid) begin
            r1_reg    <= s_coord_r;
            s1_reg    <= s_coord_s;
            sqr1_reg  <= s_coord_r * s_coord_r;
            sqs1_reg  <= s_coord_s * s_coord_s;
            rsel1_reg <= q9sf_pkg::r_sel_of(s_node_index);
            ssel1_reg <= q9sf_pkg::s_sel_of(s_node_index);
            dr1_reg   <= (s_kind == q9sf_pkg::KIND_DR);
            ds1_reg   <= (s_kind == q9sf_pkg::KIND_DS);
            en1_reg   <= (s_node_index < q9sf_pkg::NODE_COUNT) &&
                         ((s_kind == q9sf_pkg::KIND_VALUE) || (s_kind == q9sf_pkg::KIND_DR) ||
                          (s_kind == q9sf_pkg::KIND_DS));
        end
    end

    // stage 2: factors, zero for unused node or kind
    q9sf_factor u_factor_r (
        .sel   (rsel1_reg),
        .deriv (dr1_reg),
        .x     (r1_reg),
        .sq    (sqr1_reg),
        .f     (fr_next)
    );

    q9sf_factor u_factor_s (
        .sel   (ssel1_reg),
        .deriv (ds1_reg),
        .x     (s1_reg),
        .sq    (sqs1_reg),
        .f     (fs_next)
    );

    always_ff @(posedge aclk) begin
        if (rdy[1] && valid_reg[0]) begin
            fa2_reg <= en1_reg ? fr_next : '0;
            fb2_reg <= fs_next;
        end
    end

    // stage 3: four partial products
    assign al = fa2_reg[18:0];
    assign ah = fa2_reg[36:19];
    assign bl = fb2_reg[18:0];
    assign bh = fb2_reg[36:19];

    always_ff @(posedge aclk) begin
        if (rdy[2] && valid_reg[1]) begin
            ll3_reg <= al * bl;
            lh3_reg <= $signed({1'b0, al}) * bh;
            hl3_reg <= $signed({1'b0, bl}) * ah;
            hh3_reg <= ah * bh;
        end
    end

    // stage 4: middle sum, rounding offset on the low product
    always_ff @(posedge aclk) begin
        if (rdy[3] && valid_reg[2]) begin
            mid4_reg <= {lh3_reg[37], lh3_reg} + {hl3_reg[37], hl3_reg};
            hh4_reg  <= hh3_reg;
            low4_reg <= {1'b1, 8'b0, ll3_reg};
        end
    end

    // stage 5: fold high product into middle sum
    always_ff @(posedge aclk) begin
        if (rdy[4] && valid_reg[3]) begin
            acc5_reg <= {{2{hh4_reg[35]}}, hh4_reg, 19'b0} + {{18{mid4_reg[38]}}, mid4_reg};
            low5_reg <= low4_reg;
        end
    end

    // stage 6: final sum, floor shift, clamp
    always_comb begin
        tot_next = {acc5_reg[56], acc5_reg, 19'b0} + {30'b0, low5_reg};
        q_next   = tot_next[76:47];
        sat_hi   = !q_next[29] && (q_next[28:24] != 5'h00);
        sat_lo   = q_next[29] && (q_next[28:24] != 5'h1f);
        if (sat_hi) begin
            out_next = {1'b0, {(q9sf_pkg::OUT_W-1){1'b1}}};
        end else if (sat_lo) begin
            out_next = {1'b1, {(q9sf_pkg::OUT_W-1){1'b0}}};
        end else begin
            out_next = q_next[24:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[5] && valid_reg[4]) begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/q9sf_factor.sv -----
// One-dimensional quadratic Lagrange factor or its derivative, in units of 2^-31.
// Takes the coordinate and its precomputed square. Depends on q9sf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module q9sf_factor (
    input  var q9sf_pkg::sel_t    sel,
    input  var logic              deriv,
    input  var q9sf_pkg::coord_t  x,
    input  var q9sf_pkg::square_t sq,
    output var q9sf_pkg::factor_t f
);

    q9sf_pkg::factor_t sq_ext;
    q9sf_pkg::factor_t x_sh15;
    q9sf_pkg::factor_t x_sh16;
    q9sf_pkg::factor_t x_sh17;

    assign sq_ext = {sq[q9sf_pkg::SQ_W-1], sq};
    assign x_sh15 = {{4{x[q9sf_pkg::COORD_W-1]}}, x, 15'b0};
    assign x_sh16 = {{3{x[q9sf_pkg::COORD_W-1]}}, x, 16'b0};
    assign x_sh17 = {{2{x[q9sf_pkg::COORD_W-1]}}, x, 17'b0};

    always_comb begin
        unique case (sel)
            q9sf_pkg::SEL_MINUS: begin
                f = deriv ? (x_sh16 - q9sf_pkg::FACT_TWO30) : (sq_ext - x_sh15);
            end
            q9sf_pkg::SEL_PLUS: begin
                f = deriv ? (x_sh16 + q9sf_pkg::FACT_TWO30) : (sq_ext + x_sh15);
            end
            q9sf_pkg::SEL_CENTER: begin
                f = deriv ? (37'sd0 - x_sh17) : (q9sf_pkg::FACT_TWO31 - {sq, 1'b0});
            end
            default: begin
                f = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- tb/quad9_shape_function_eval_tb.sv -----
// Self-checking testbench for quad9_shape_function_eval: directed table, then random requests.
// Depends on q9sf_pkg and the DUT sources; results are checked in order against table values or a local predictor.
`timescale 1ns / 1ps

module quad9_shape_function_eval_tb;

    localparam logic [q9sf_pkg::KIND_W-1:0] KIND_NONE = 2'd3;
    localparam int RANDOM_REQUESTS = 800;
    localparam int IDLE_LIMIT      = 4000;
    localparam int TAIL_CYCLES     = 24;

    typedef logic signed [q9sf_pkg::OUT_W-1:0] shape_t;
    typedef logic signed [47:0]                poly_t;
    typedef logic signed [95:0]                wide_t;

    typedef struct packed {
        logic [q9sf_pkg::NODE_W-1:0] node;
        logic [q9sf_pkg::KIND_W-1:0] kind;
        q9sf_pkg::coord_t            r;
        q9sf_pkg::coord_t            s;
        logic                        typed;
        shape_t                      value;
    } probe_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [3:0]        s_node_index = '0;
    logic [1:0]        s_kind = '0;
    q9sf_pkg::coord_t  s_coord_r = '0;
    q9sf_pkg::coord_t  s_coord_s = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    shape_t            m_shape_value;

    shape_t            expected_shapes[$];
    probe_t            directed_rows[$];
    int unsigned       error_count = 0;
    int unsigned       requests_sent = 0;
    int unsigned       outside_requests = 0;
    int unsigned       results_checked = 0;
    int unsigned       idle_cycles = 0;

    quad9_shape_function_eval DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_node_index  (s_node_index),
        .s_kind        (s_kind),
        .s_coord_r     (s_coord_r),
        .s_coord_s     (s_coord_s),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_shape_value (m_shape_value)
    );

    always #1 aclk = ~aclk;

    function automatic q9sf_pkg::sel_t r_factor_sel(input logic [q9sf_pkg::NODE_W-1:0] node);
        case (node)
            4'd0, 4'd3, 4'd7: return q9sf_pkg::SEL_MINUS;
            4'd1, 4'd2, 4'd5: return q9sf_pkg::SEL_PLUS;
            default:          return q9sf_pkg::SEL_CENTER;
        endcase
    endfunction

    function automatic q9sf_pkg::sel_t s_factor_sel(input logic [q9sf_pkg::NODE_W-1:0] node);
        case (node)
            4'd0, 4'd1, 4'd4: return q9sf_pkg::SEL_MINUS;
            4'd2, 4'd3, 4'd6: return q9sf_pkg::SEL_PLUS;
            default:          return q9sf_pkg::SEL_CENTER;
        endcase
    endfunction

    // one-dimensional quadratic factor or its slope, in units of 2^-31
    function automatic poly_t lagrange_factor(input q9sf_pkg::sel_t sel, input bit deriv,
                                              input q9sf_pkg::coord_t x);
        poly_t xv;
        poly_t one;
        xv  = x;
        one = poly_t'(1) <<< 15;
        if (!deriv) begin
            case (sel)
                q9sf_pkg::SEL_MINUS: return xv * (xv - one);
                q9sf_pkg::SEL_PLUS:  return xv * (xv + one);
                default:             return (poly_t'(1) <<< 31) - 2 * xv * xv;
            endcase
        end
        case (sel)
            q9sf_pkg::SEL_MINUS: return (2 * xv - one) * one;
            q9sf_pkg::SEL_PLUS:  return (2 * xv + one) * one;
            default:             return -2 * xv * (poly_t'(1) <<< 16);
        endcase
    endfunction

    function automatic shape_t shape_function_value(input logic [q9sf_pkg::NODE_W-1:0] node,
                                                    input logic [q9sf_pkg::KIND_W-1:0] kind,
                                                    input q9sf_pkg::coord_t r,
                                                    input q9sf_pkg::coord_t s);
        wide_t fr;
        wide_t fs;
        wide_t rounded;
        wide_t top;
        wide_t bottom;
        if (node >= q9sf_pkg::NODE_COUNT || kind == KIND_NONE)
            return '0;
        fr      = lagrange_factor(r_factor_sel(node), kind == q9sf_pkg::KIND_DR, r);
        fs      = lagrange_factor(s_factor_sel(node), kind == q9sf_pkg::KIND_DS, s);
        rounded = (fr * fs + (wide_t'(1) <<< 46)) >>> 47;
        top     = (wide_t'(1) <<< (q9sf_pkg::OUT_W - 1)) - 1;
        bottom  = -(wide_t'(1) <<< (q9sf_pkg::OUT_W - 1));
        if (rounded > top)
            rounded = top;
        if (rounded < bottom)
            rounded = bottom;
        return rounded[q9sf_pkg::OUT_W-1:0];
    endfunction

    function automatic int unsigned pick_gap(input bit calm);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 45)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic q9sf_pkg::coord_t pick_coord();
        int unsigned roll;
        int          near;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return q9sf_pkg::coord_t'(int'($urandom_range(0, 65536)) - 32768);
        if (roll < 60) begin
            near = (int'($urandom_range(0, 2)) - 1) * 32768;
            return q9sf_pkg::coord_t'(near + int'($urandom_range(0, 6)) - 3);
        end
        if (roll < 70)
            return $urandom_range(0, 1) ? q9sf_pkg::coord_t'(-131072)
                                        : q9sf_pkg::coord_t'(131071);
        return q9sf_pkg::coord_t'($urandom);
    endfunction

    task automatic add_row(input logic [q9sf_pkg::NODE_W-1:0] node,
                           input logic [q9sf_pkg::KIND_W-1:0] kind,
                           input q9sf_pkg::coord_t r, input q9sf_pkg::coord_t s,
                           input logic typed, input shape_t value);
        directed_rows.push_back('{node, kind, r, s, typed, value});
    endtask

    task automatic report_mismatch(input string what, input shape_t want, input shape_t got);
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        error_count++;
    endtask

    // drive one request and return at the edge that accepts it
    task automatic send_request(input logic [q9sf_pkg::NODE_W-1:0] node,
                                input logic [q9sf_pkg::KIND_W-1:0] kind,
                                input q9sf_pkg::coord_t r, input q9sf_pkg::coord_t s,
                                input int unsigned gap);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_node_index <= node;
        s_kind       <= kind;
        s_coord_r    <= r;
        s_coord_s    <= s;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        requests_sent++;
        if (node >= q9sf_pkg::NODE_COUNT || kind == KIND_NONE)
            outside_requests++;
    endtask

    initial begin
        probe_t                      row;
        logic [q9sf_pkg::NODE_W-1:0] node;
        logic [q9sf_pkg::KIND_W-1:0] kind;
        q9sf_pkg::coord_t            r;
        q9sf_pkg::coord_t            s;
        bit                          calm;

        calm = 1'b0;
        add_row(4'd8,  q9sf_pkg::KIND_VALUE, 0,       0,       1'b1, 25'sd32768);
        add_row(4'd0,  q9sf_pkg::KIND_VALUE, 0,       0,       1'b1, 25'sd0);
        add_row(4'd0,  q9sf_pkg::KIND_VALUE, -32768,  -32768,  1'b1, 25'sd32768);
        add_row(4'd2,  q9sf_pkg::KIND_VALUE, 32768,   32768,   1'b1, 25'sd32768);
        add_row(4'd0,  q9sf_pkg::KIND_VALUE, -131072, -131072, 1'b1, 25'sd3276800);
        add_row(4'd8,  q9sf_pkg::KIND_VALUE, -131072, -131072, 1'b1, 25'sd7372800);
        add_row(4'd8,  q9sf_pkg::KIND_VALUE, 131071,  131071,  1'b0, '0);
        add_row(4'd2,  q9sf_pkg::KIND_VALUE, 131071,  131071,  1'b0, '0);
        add_row(4'd4,  q9sf_pkg::KIND_DR,    -131072, 131071,  1'b0, '0);
        add_row(4'd5,  q9sf_pkg::KIND_DS,    131071,  -131072, 1'b0, '0);
        add_row(4'd1,  q9sf_pkg::KIND_DR,    0,       0,       1'b0, '0);
        add_row(4'd9,  q9sf_pkg::KIND_VALUE, 16384,   16384,   1'b1, 25'sd0);
        add_row(4'd15, q9sf_pkg::KIND_DS,    -131072, 131071,  1'b1, 25'sd0);
        add_row(4'd0,  KIND_NONE,            -131072, -131072, 1'b1, 25'sd0);
        add_row(4'd8,  q9sf_pkg::KIND_DR,    1,       16384,   1'b1, -25'sd1);
        add_row(4'd8,  q9sf_pkg::KIND_DR,    -1,      16384,   1'b1, 25'sd2);
        add_row(4'd7,  q9sf_pkg::KIND_DS,    -1,      -1,      1'b0, '0);
        add_row(4'd3,  q9sf_pkg::KIND_DR,    32768,   -32768,  1'b0, '0);
        add_row(4'd6,  q9sf_pkg::KIND_DS,    16384,   -16384,  1'b0, '0);
        add_row(4'd1,  q9sf_pkg::KIND_DS,    -32768,  32768,   1'b0, '0);
        add_row(4'd6,  q9sf_pkg::KIND_VALUE, 98304,   -98304,  1'b0, '0);
        add_row(4'd4,  q9sf_pkg::KIND_VALUE, -12345,  23456,   1'b0, '0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_request(row.node, row.kind, row.r, row.s, pick_gap(i < 8));
            expected_shapes.push_back(row.typed ? row.value
                                      : shape_function_value(row.node, row.kind, row.r, row.s));
        end

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 50 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_REQUESTS / 2) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (expected_shapes.size() != 0) @(posedge aclk);
            end
            node = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 8)) : 4'($urandom);
            kind = ($urandom_range(0, 19) < 17) ? 2'($urandom_range(0, 2)) : 2'($urandom);
            r    = pick_coord();
            s    = pick_coord();
            send_request(node, kind, r, s, pick_gap(calm));
            expected_shapes.push_back(shape_function_value(node, kind, r, s));
        end
        s_valid <= 1'b0;

        while (expected_shapes.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_shapes.size() != 0) begin
            $display("%0d results never arrived", expected_shapes.size());
            error_count++;
        end

        $display("Covered %0d requests (%0d directed, %0d with node or kind out of range),",
                 requests_sent, directed_rows.size(), outside_requests);
        $display("%0d results checked, %0d mismatches.", results_checked, error_count);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        int unsigned stall;
        bit          calm;

        calm = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 19) == 0)
                calm = ~calm;
            m_ready <= 1'b1;
            repeat (1 + $urandom_range(0, 12)) @(posedge aclk);
            stall = pick_gap(calm);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_shapes.size() == 0) begin
                report_mismatch("unexpected result", '0, m_shape_value);
            end else begin
                if (m_shape_value !== expected_shapes[0])
                    report_mismatch("shape_value", expected_shapes[0], m_shape_value);
                void'(expected_shapes.pop_front());
                results_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

endmodule

// ----- quad9_shape_function_eval.f -----
src/q9sf_pkg.sv
src/q9sf_factor.sv
src/quad9_shape_function_eval.sv
tb/quad9_shape_function_eval_tb.sv
